FILE: rtl/assert_macros.svh
// Assertion macros for the timer RTL.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked property that is also checked during reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/spwm_pkg.sv
// Shared types and constants for the four-channel servo PWM timer.
// No dependencies; imported by every module of the block.
package spwm_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int MAX_CHANNELS = 4;
   localparam int COUNT_BITS   = 16;
   localparam int WIDTH_BITS   = 16;
   localparam int PRESC_BITS   = 16;
   localparam int DIV_BITS     = PRESC_BITS + 1;
   localparam int CHAN_BITS    = 3;
   localparam int EN_BITS      = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = DIV_BITS;

   // Largest useful prescale divider
   localparam logic [DIV_BITS-1:0] DIV_MAX = DIV_BITS'(1) << PRESC_BITS;
   localparam logic [DIV_BITS-1:0] DIV_MIN = DIV_BITS'(1);

   // Reset values of the configuration registers
   localparam logic [DIV_BITS-1:0]   RESET_PRESCALE = DIV_BITS'(72);
   localparam logic [COUNT_BITS-1:0] RESET_PERIOD   = COUNT_BITS'(19999);
   localparam logic [WIDTH_BITS-1:0] RESET_MIN      = WIDTH_BITS'(1000);
   localparam logic [WIDTH_BITS-1:0] RESET_MAX      = WIDTH_BITS'(2000);
   localparam logic [EN_BITS-1:0]    RESET_ENABLE   = EN_BITS'(15);

   // Item kinds
   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_SET_ONE = 2'd1,
      KIND_SET_ALL = 2'd2,
      KIND_STOP    = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PRESCALE = 3'd0,
      CSR_PERIOD   = 3'd1,
      CSR_PULSE_MIN = 3'd2,
      CSR_PULSE_MAX = 3'd3,
      CSR_ENABLE   = 3'd4
   } csr_index_type;

   // Per-lane control from the dispatch logic
   typedef struct packed {
      logic fire;     // an item transfers this cycle
      logic wr;       // load clamped width into preload
      logic stop;     // load pulse_min into preload
      logic update;   // counter wrap: copy preload to active
      logic enable;   // channel output enable
   } spwm_lane_ctrl_type;

endpackage

FILE: rtl/spwm_count.sv
// Prescaler and main counter of the PWM timer; raises the update event on wrap.
// Depends on spwm_pkg.
module spwm_count
   import spwm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick,          // tick item transfers
   input  logic [DIV_BITS-1:0]     prescale_div,
   input  logic [COUNT_BITS-1:0]   period_minus_one,
   output logic [COUNT_BITS-1:0]   count_next,    // counter after this item
   output logic                    update         // wrap on this item
);

   logic [PRESC_BITS-1:0] presc_ff, presc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0]   div_eff;
   logic [DIV_BITS-1:0]   presc_inc;

   // Divider limits: zero acts as one, large values saturate
   always_comb begin
      if (prescale_div == '0) begin
         div_eff = DIV_MIN;
      end else if (prescale_div > DIV_MAX) begin
         div_eff = DIV_MAX;
      end else begin
         div_eff = prescale_div;
      end
   end

   assign presc_inc = {1'b0, presc_ff} + DIV_BITS'(1);

   // Next counter state
   always_comb begin
      presc_in = presc_ff;
      count_in = count_ff;
      update   = 1'b0;
      if (tick) begin
         if (presc_inc >= div_eff) begin
            presc_in = '0;
            if (count_ff >= period_minus_one) begin
               count_in = '0;
               update   = 1'b1;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end else begin
            presc_in = presc_inc[PRESC_BITS-1:0];
         end
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         presc_ff <= '0;
         count_ff <= '0;
      end else begin
         presc_ff <= presc_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/spwm_lane.sv
// One PWM channel: width clamp, preload and active compare, pin compare.
// Depends on spwm_pkg.
module spwm_lane
   import spwm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  spwm_lane_ctrl_type      ctrl,
   input  logic [WIDTH_BITS-1:0]   width,
   input  logic [WIDTH_BITS-1:0]   pulse_min,
   input  logic [WIDTH_BITS-1:0]   pulse_max,
   input  logic [COUNT_BITS-1:0]   count_next,
   output logic                    pin
);

   logic [WIDTH_BITS-1:0] preload_ff, preload_in;
   logic [WIDTH_BITS-1:0] active_ff, active_in;
   logic [WIDTH_BITS-1:0] clamped;

   // Minimum tested first, so with inverted limits the minimum takes priority
   always_comb begin
      if (width < pulse_min) begin
         clamped = pulse_min;
      end else if (width > pulse_max) begin
         clamped = pulse_max;
      end else begin
         clamped = width;
      end
   end

   // Preload and active compare updates
   always_comb begin
      preload_in = preload_ff;
      active_in  = active_ff;
      if (ctrl.fire) begin
         if (ctrl.stop) begin
            preload_in = pulse_min;
         end else if (ctrl.wr) begin
            preload_in = clamped;
         end
         if (ctrl.update) begin
            active_in = preload_ff;
         end
      end
   end

   // Level after this item (PWM mode 1)
   assign pin = ctrl.enable && (count_next < active_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         preload_ff <= RESET_MIN;
         active_ff  <= RESET_MIN;
      end else begin
         preload_ff <= preload_in;
         active_ff  <= active_in;
      end
   end

endmodule

FILE: rtl/servo_pwm_timer_four_channel_top.sv
// Four-channel servo PWM timer, top level: config registers, lane dispatch,
// pin merge and result register. Depends on spwm_pkg, spwm_count, spwm_lane.
//
// Each transfer on req_ is a tick, a single-channel width write, an all-channel
// write or a stop, and yields exactly one result on rsp_: the pin levels, the
// main counter and whether this tick wrapped the counter and loaded the compares.
// Counter, four lanes and the pin compare settle in the cycle of the transfer
// and land in the result register, so one item per clock is accepted whenever
// the result register is empty or being emptied. Widths are
// clamped to pulse_min..pulse_max into preloads; preloads reach the active
// compares on the counter wrap. Configuration writes on csr_ take effect at once
// and belong only in idle periods.
module servo_pwm_timer_four_channel_top
   import spwm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // item channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [CHAN_BITS-1:0]      req_channel,
   input  logic [WIDTH_BITS-1:0]     req_width_a,
   input  logic [WIDTH_BITS-1:0]     req_width_b,
   input  logic [WIDTH_BITS-1:0]     req_width_c,
   input  logic [WIDTH_BITS-1:0]     req_width_d,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [MAX_CHANNELS-1:0]   rsp_pwm_pins,
   output logic [COUNT_BITS-1:0]     rsp_count_now,
   output logic                      rsp_update_seen,
   // configuration
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

`include "assert_macros.svh"

   logic [DIV_BITS-1:0]   prescale_ff;
   logic [COUNT_BITS-1:0] period_ff;
   logic [WIDTH_BITS-1:0] min_ff;
   logic [WIDTH_BITS-1:0] max_ff;
   logic [EN_BITS-1:0]    enable_ff;

   logic                  req_fire;
   kind_type              kind;
   logic                  tick;
   logic [COUNT_BITS-1:0] count_next;
   logic                  update;

   logic [WIDTH_BITS-1:0] width_all [MAX_CHANNELS];
   logic [WIDTH_BITS-1:0] lane_width [NUM_CHANNELS];
   spwm_lane_ctrl_type    lane_ctrl [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] lane_pin;
   logic [MAX_CHANNELS-1:0] pins;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MAX_CHANNELS-1:0] pins_ff;
   logic [COUNT_BITS-1:0]   count_now_ff;
   logic                    update_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= RESET_PRESCALE;
         period_ff   <= RESET_PERIOD;
         min_ff      <= RESET_MIN;
         max_ff      <= RESET_MAX;
         enable_ff   <= RESET_ENABLE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESCALE:  prescale_ff <= csr_wdata;
            CSR_PERIOD:    period_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_PULSE_MIN: min_ff      <= csr_wdata[WIDTH_BITS-1:0];
            CSR_PULSE_MAX: max_ff      <= csr_wdata[WIDTH_BITS-1:0];
            CSR_ENABLE:    enable_ff   <= csr_wdata[EN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: take an item whenever the result register frees up
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);
   assign tick      = req_fire && (kind == KIND_TICK);

   spwm_count u_count (
      .clock            (clock),
      .reset            (reset),
      .tick             (tick),
      .prescale_div     (prescale_ff),
      .period_minus_one (period_ff),
      .count_next       (count_next),
      .update           (update)
   );

   assign width_all[0] = req_width_a;
   assign width_all[1] = req_width_b;
   assign width_all[2] = req_width_c;
   assign width_all[3] = req_width_d;

   // Lanes, one per channel
   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
      always_comb begin
         lane_ctrl[i].fire   = req_fire;
         lane_ctrl[i].wr     = (kind == KIND_SET_ALL) ||
                               ((kind == KIND_SET_ONE) &&
                                (req_channel == CHAN_BITS'(i + 1)));
         lane_ctrl[i].stop   = (kind == KIND_STOP);
         lane_ctrl[i].update = update;
         lane_ctrl[i].enable = enable_ff[i];
         lane_width[i]       = (kind == KIND_SET_ALL) ? width_all[i] : req_width_a;
      end

      spwm_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl[i]),
         .width      (lane_width[i]),
         .pulse_min  (min_ff),
         .pulse_max  (max_ff),
         .count_next (count_next),
         .pin        (lane_pin[i])
      );
   end

   // Merge lane pins; unused channels read low
   always_comb begin
      pins = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         pins[i] = lane_pin[i];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pins_ff      <= pins;
         count_now_ff <= count_next;
         update_ff    <= update;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pwm_pins    = pins_ff;
   assign rsp_count_now   = count_now_ff;
   assign rsp_update_seen = update_ff;

   // Checks
   `ASSERT_CLK(a_update_zero, rsp_valid && rsp_update_seen |-> rsp_count_now == '0, "update without counter wrap")
   `ASSERT_CLK(a_no_update_nontick, req_fire && !tick |=> !rsp_update_seen, "update on a non-tick item")
   `ASSERT_CLK(a_count_hold, req_fire && !tick |=> rsp_count_now == $past(count_next), "counter result mismatch")
   `ASSERT_ALWAYS(a_no_accept_when_full, rsp_valid_ff && !rsp_ready |-> !req_ready, "accept while result stalled")

endmodule
